// ===== sv/kcc_pkg.sv =====
// Shared types and constants of the keypad calculator core.
package kcc_pkg;

	// Fixed field widths of the key and result words
	localparam int unsigned OPER_W  = 3;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned SHOWN_W = 32;

	// Key event codes
	typedef enum logic [OPER_W-1:0] {
		OP_DIGIT   = 3'd0,
		OP_OPER    = 3'd1,
		OP_EQUALS  = 3'd2,
		OP_MEMPLUS = 3'd3,
		OP_MEMCLR  = 3'd4,
		OP_RECALL  = 3'd5,
		OP_ALLCLR  = 3'd6
	} kcc_op_t;

	// Pending arithmetic operator codes
	typedef enum logic [CODE_W-1:0] {
		OPR_ADD = 3'd0,
		OPR_SUB = 3'd1,
		OPR_MUL = 3'd2,
		OPR_DIV = 3'd3,
		OPR_EQ  = 3'd4
	} kcc_opr_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT,
		ST_WRITE
	} kcc_state_t;

	// Request to the shared multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} kcc_md_req_t;

	// Map a raw operator key code onto a stored operator
	function automatic kcc_opr_t map_opr(input logic [CODE_W-1:0] code);
		kcc_opr_t r;
		case (code)
			OPR_ADD: r = OPR_ADD;
			OPR_SUB: r = OPR_SUB;
			OPR_MUL: r = OPR_MUL;
			OPR_DIV: r = OPR_DIV;
			default: r = OPR_EQ;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/kcc_if.sv =====
// Valid/ready channel interfaces for key words and result words.
interface kcc_in_if import kcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPER_W-1:0]   operation;
	logic [DIGIT_W-1:0]  digit_value;
	logic [CODE_W-1:0]   operator_code;

	modport source (output valid, operation, digit_value, operator_code, input ready);
	modport sink (input valid, operation, digit_value, operator_code, output ready);
endinterface

interface kcc_out_if import kcc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SHOWN_W-1:0]  shown_result;
	logic signed [SHOWN_W-1:0]  shown_display;
	logic signed [SHOWN_W-1:0]  shown_memory;
	logic                       error_flag;

	modport source (output valid, shown_result, shown_display, shown_memory, error_flag,
		input ready);
	modport sink (input valid, shown_result, shown_display, shown_memory, error_flag,
		output ready);
endinterface

// ===== sv/keypad_calculator_core_top.sv =====
// Keypad calculator core: key sequencer, value registers and result register.
// One key word goes in at a time. A key word that needs no multiply or divide passes
// through the execute and write states to its result word; an operator or equals key that
// applies a pending multiply or divide also waits in the wait state between them for the
// shared bit-serial multiply/divide unit, which resolves one bit per cycle. The sequencer
// is ready for the next key word in the cycle after a result word is loaded into the output
// register, even while that word still waits for the sink. Values wrap at VALUE_WIDTH
// bits and are shown sign-extended or cut to 32 bits.
module keypad_calculator_core_top import kcc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	kcc_in_if.sink   in_ch,
	kcc_out_if.source out_ch
);

	localparam int unsigned W = VALUE_WIDTH;

	kcc_state_t           state_q;
	kcc_state_t           state_nxt;

	// Latched key word
	kcc_op_t              op_q;
	logic [DIGIT_W-1:0]   dv_q;
	logic [CODE_W-1:0]    code_q;

	// Calculator state
	logic [W-1:0]         disp_q;
	logic [W-1:0]         acc_q;
	logic [W-1:0]         mem_q;
	kcc_opr_t             pend_q;
	logic                 err_q;

	// Output register
	logic                 out_valid_q;
	logic [SHOWN_W-1:0]   res_out_q;
	logic [SHOWN_W-1:0]   disp_out_q;
	logic [SHOWN_W-1:0]   mem_out_q;
	logic                 err_out_q;

	// Next-value logic
	logic [W-1:0]         disp_nxt;
	logic [W-1:0]         acc_nxt;
	logic [W-1:0]         mem_nxt;
	kcc_opr_t             pend_nxt;
	logic                 err_nxt;
	logic [W-1:0]         digit_val;
	logic [W-1:0]         disp_x10;
	logic [W-1:0]         apply_val;
	logic                 apply_fail;
	logic                 needs_apply;
	logic                 use_md;
	logic                 slot_free;
	logic                 in_ready;
	logic                 out_load;
	kcc_md_req_t          md_req;
	logic                 md_done;
	logic [W-1:0]         md_res;

	assign slot_free = !out_valid_q || out_ch.ready;

	// Digit entry: multiply by ten, then move the digit away from zero in the direction of the sign
	assign disp_x10  = {disp_q[W-4:0], 3'b000} + {disp_q[W-2:0], 1'b0};
	assign digit_val = disp_q[W-1] ? (disp_x10 - W'(dv_q)) : (disp_x10 + W'(dv_q));

	// Combinational part of applying the pending operator
	always_comb begin
		apply_fail = 1'b0;
		case (pend_q)
			OPR_ADD: apply_val = acc_q + disp_q;
			OPR_SUB: apply_val = acc_q - disp_q;
			OPR_DIV: begin
				apply_val  = '0;
				apply_fail = (disp_q == '0);
			end
			OPR_MUL: apply_val = '0;
			default: apply_val = disp_q;
		endcase
	end

	assign needs_apply = (op_q == OP_OPER) || ((op_q == OP_EQUALS) && !err_q);
	assign use_md      = needs_apply &&
		((pend_q == OPR_MUL) || ((pend_q == OPR_DIV) && (disp_q != '0)));

	// Next state of the sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_ch.valid) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = use_md ? ST_WAIT : ST_WRITE;
			ST_WAIT:  if (md_done) state_nxt = ST_WRITE;
			ST_WRITE: if (slot_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready      = 1'b0;
		out_load      = 1'b0;
		md_req.start  = 1'b0;
		md_req.is_div = (pend_q == OPR_DIV);
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_EXEC:  md_req.start = use_md;
			ST_WRITE: out_load = slot_free;
			default:  ;
		endcase
	end

	// Next calculator state for the current key word
	always_comb begin
		disp_nxt = disp_q;
		acc_nxt  = acc_q;
		mem_nxt  = mem_q;
		pend_nxt = pend_q;
		err_nxt  = err_q;
		if (state_q == ST_WAIT) begin
			acc_nxt = md_res;
			if (op_q == OP_OPER) begin
				disp_nxt = '0;
				pend_nxt = map_opr(code_q);
			end else begin
				disp_nxt = md_res;
				pend_nxt = OPR_EQ;
			end
		end else begin
			case (op_q)
				OP_DIGIT: disp_nxt = digit_val;
				OP_OPER: begin
					acc_nxt  = apply_fail ? '0 : apply_val;
					err_nxt  = err_q | apply_fail;
					disp_nxt = '0;
					pend_nxt = map_opr(code_q);
				end
				OP_EQUALS: begin
					if (err_q) begin
						disp_nxt = '0;
						acc_nxt  = '0;
					end else begin
						acc_nxt  = apply_fail ? '0 : apply_val;
						disp_nxt = apply_fail ? '0 : apply_val;
						err_nxt  = apply_fail;
						pend_nxt = OPR_EQ;
					end
				end
				OP_MEMPLUS: mem_nxt = mem_q + disp_q;
				OP_MEMCLR:  mem_nxt = '0;
				OP_RECALL:  disp_nxt = mem_q;
				OP_ALLCLR: begin
					disp_nxt = '0;
					acc_nxt  = '0;
					mem_nxt  = '0;
					pend_nxt = OPR_EQ;
					err_nxt  = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Advance the sequencer and update calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			disp_q  <= '0;
			acc_q   <= '0;
			mem_q   <= '0;
			pend_q  <= OPR_EQ;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_EXEC && !use_md) || (state_q == ST_WAIT && md_done)) begin
				disp_q <= disp_nxt;
				acc_q  <= acc_nxt;
				mem_q  <= mem_nxt;
				pend_q <= pend_nxt;
				err_q  <= err_nxt;
			end
		end
	end

	// Hold the accepted key word
	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			op_q   <= kcc_op_t'(in_ch.operation);
			dv_q   <= in_ch.digit_value;
			code_q <= in_ch.operator_code;
		end
	end

	// Result word valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_out_q  <= SHOWN_W'($signed(acc_q));
			disp_out_q <= SHOWN_W'($signed(disp_q));
			mem_out_q  <= SHOWN_W'($signed(mem_q));
			err_out_q  <= err_q;
		end
	end

	kcc_muldiv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (acc_q),
		.b      (disp_q),
		.done   (md_done),
		.result (md_res)
	);

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.shown_result  = res_out_q;
	assign out_ch.shown_display = disp_out_q;
	assign out_ch.shown_memory  = mem_out_q;
	assign out_ch.error_flag    = err_out_q;

endmodule

// ===== sv/kcc_muldiv.sv =====
// Bit-serial shared unit: wrapping multiply or signed truncating divide.
module kcc_muldiv import kcc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kcc_md_req_t            req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = $clog2(W);

	logic                 busy_q;
	logic                 done_q;
	logic                 div_q;
	logic                 neg_q;
	logic [CW-1:0]        cnt_q;
	logic [W-1:0]         x_q;
	logic [W-1:0]         y_q;
	logic [W:0]           acc_q;

	logic [W-1:0]         mag_a;
	logic [W-1:0]         mag_b;
	logic [W:0]           rem_sh;
	logic [W:0]           rem_diff;
	logic [W-1:0]         quo;

	// Take operand magnitudes for the divider
	assign mag_a = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[W-1] ? (~b + 1'b1) : b;

	// One restoring-division step
	assign rem_sh   = {acc_q[W-1:0], x_q[W-1]};
	assign rem_diff = rem_sh - {1'b0, y_q};

	// Control: count one bit per cycle, pulse done after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift-add or shift-subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
			if (req.is_div) begin
				x_q <= mag_a;
				y_q <= mag_b;
			end else begin
				x_q <= a;
				y_q <= b;
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (!rem_diff[W]) begin
					acc_q <= rem_diff;
					x_q   <= {x_q[W-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					x_q   <= {x_q[W-2:0], 1'b0};
				end
			end else begin
				if (y_q[0]) begin
					acc_q <= {1'b0, acc_q[W-1:0] + x_q};
				end
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
		end
	end

	// Apply the quotient sign
	assign quo    = neg_q ? (~x_q + 1'b1) : x_q;
	assign result = div_q ? quo : acc_q[W-1:0];
	assign done   = done_q;

endmodule

// ===== sv/kcc_checker.sv =====
// Port-level checks of the keypad calculator core, bound to the top level.
module kcc_checker import kcc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [SHOWN_W-1:0] out_result,
	input logic [SHOWN_W-1:0] out_display,
	input logic [SHOWN_W-1:0] out_memory,
	input logic               out_error
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] open_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track key words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_acc && !out_acc) begin
			open_q <= open_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result) &&
		$stable(out_display) && $stable(out_memory) && $stable(out_error))
		else $error("stalled result word changed");

	// Busy right after taking a key word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("key word taken on consecutive cycles");

	// No result word without a key word behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 2'd0)
		else $error("result word without a pending key word");

	// At most one key word waits behind an unanswered result
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> open_q < 2'd2)
		else $error("too many key words in flight");

endmodule

bind keypad_calculator_core_top kcc_checker u_kcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_result  (out_ch.shown_result),
	.out_display (out_ch.shown_display),
	.out_memory  (out_ch.shown_memory),
	.out_error   (out_ch.error_flag)
);

// ===== tb/tb_keypad_calculator_core_top.sv =====
// Self-checking testbench of the keypad calculator core: key stimulus, shadow model, checks.
module tb_keypad_calculator_core_top import kcc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUE_W = SHOWN_W;
	localparam int unsigned RANDOM_KEYS = 1450;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned HOLDOFF_AT = 200;
	localparam int unsigned HOLDOFF_CYCLES = 400;
	localparam logic [VALUE_W-1:0] DECIMAL_BASE = 10;
	localparam logic [OPER_W-1:0] OP_NOP = {OPER_W{1'b1}};
	localparam logic [CODE_W-1:0] CODE_TOP = {CODE_W{1'b1}};

	typedef struct {
		logic [OPER_W-1:0]  operation;
		logic [DIGIT_W-1:0] digit_value;
		logic [CODE_W-1:0]  operator_code;
	} key_word_t;

	typedef struct {
		logic [SHOWN_W-1:0] result;
		logic [SHOWN_W-1:0] display;
		logic [SHOWN_W-1:0] memory;
		logic               error;
	} readout_t;

	// Shadow calculator: tracks the registers and queues the readouts they imply
	class calc_shadow;
		logic [VALUE_W-1:0] display;
		logic [VALUE_W-1:0] accum;
		logic [VALUE_W-1:0] memory;
		kcc_opr_t           pend_opr;
		logic               error;
		readout_t           readouts[$];
		int unsigned        failures;
		int unsigned        div_zero_events;
		int unsigned        keys_seen;
		int unsigned        words_checked;

		function new();
			display = '0;
			accum = '0;
			memory = '0;
			pend_opr = OPR_EQ;
			error = 1'b0;
			failures = 0;
			div_zero_events = 0;
			keys_seen = 0;
			words_checked = 0;
		endfunction

		// Signed quotient truncated toward zero, computed on magnitudes so min / -1 wraps
		function logic [VALUE_W-1:0] quotient(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
			logic [VALUE_W-1:0] ma;
			logic [VALUE_W-1:0] mb;
			logic [VALUE_W-1:0] q;
			ma = a[VALUE_W-1] ? -a : a;
			mb = b[VALUE_W-1] ? -b : b;
			q = ma / mb;
			return (a[VALUE_W-1] ^ b[VALUE_W-1]) ? -q : q;
		endfunction

		// Fold the display into the accumulator; report division by zero as 0
		function bit apply_pending();
			case (pend_opr)
				OPR_ADD: accum = accum + display;
				OPR_SUB: accum = accum - display;
				OPR_MUL: accum = accum * display;
				OPR_DIV: begin
					if (display == '0) begin
						div_zero_events++;
						return 1'b0;
					end
					accum = quotient(accum, display);
				end
				default: accum = display;
			endcase
			return 1'b1;
		endfunction

		// Advance the shadow registers by one accepted key word
		function void note_key(key_word_t k);
			logic [VALUE_W-1:0] dv;
			readout_t           r;
			dv = VALUE_W'(k.digit_value);
			keys_seen++;
			case (k.operation)
				OP_DIGIT: begin
					if (display[VALUE_W-1])
						display = display * DECIMAL_BASE - dv;
					else
						display = display * DECIMAL_BASE + dv;
				end
				OP_OPER: begin
					if (!apply_pending()) begin
						accum = '0;
						error = 1'b1;
					end
					display = '0;
					pend_opr = (k.operator_code <= OPR_EQ) ? kcc_opr_t'(k.operator_code) : OPR_EQ;
				end
				OP_EQUALS: begin
					if (error) begin
						display = '0;
						accum = '0;
					end else if (pend_opr == OPR_EQ) begin
						accum = display;
					end else begin
						if (apply_pending()) begin
							display = accum;
						end else begin
							display = '0;
							accum = '0;
							error = 1'b1;
						end
						pend_opr = OPR_EQ;
					end
				end
				OP_MEMPLUS: memory = memory + display;
				OP_MEMCLR:  memory = '0;
				OP_RECALL:  display = memory;
				OP_ALLCLR: begin
					display = '0;
					accum = '0;
					memory = '0;
					pend_opr = OPR_EQ;
					error = 1'b0;
				end
				default: ;
			endcase
			r.result = SHOWN_W'($signed(accum));
			r.display = SHOWN_W'($signed(display));
			r.memory = SHOWN_W'($signed(memory));
			r.error = error;
			readouts.push_back(r);
		endfunction

		// Compare one result word with the oldest queued readout
		function void check_readout(logic [SHOWN_W-1:0] res, logic [SHOWN_W-1:0] disp,
			logic [SHOWN_W-1:0] mem, logic err);
			readout_t e;
			words_checked++;
			if (readouts.size() == 0) begin
				$error("result word arrived with no readout queued");
				failures++;
				return;
			end
			e = readouts.pop_front();
			if (res !== e.result) begin
				$error("shown_result: expected %0d, got %0d", $signed(e.result), $signed(res));
				failures++;
			end
			if (disp !== e.display) begin
				$error("shown_display: expected %0d, got %0d", $signed(e.display), $signed(disp));
				failures++;
			end
			if (mem !== e.memory) begin
				$error("shown_memory: expected %0d, got %0d", $signed(e.memory), $signed(mem));
				failures++;
			end
			if (err !== e.error) begin
				$error("error_flag: expected %0b, got %0b", e.error, err);
				failures++;
			end
		endfunction

		function int unsigned outstanding();
			return readouts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kcc_in_if  in_ch ();
	kcc_out_if out_ch ();

	keypad_calculator_core_top #(
		.VALUE_WIDTH(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	calc_shadow  shadow;
	key_word_t   key_plan[$];
	int unsigned idle_cycles;

	// Free-running clock, 4 ns period
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Queue one key word; fields the operation ignores get random content
	task automatic push_key(logic [OPER_W-1:0] op, logic [DIGIT_W-1:0] dv = '0,
		logic [CODE_W-1:0] code = '0);
		key_word_t k;
		k.operation = op;
		k.digit_value = (op == OP_DIGIT) ? dv : DIGIT_W'($urandom);
		k.operator_code = (op == OP_OPER) ? code : CODE_W'($urandom);
		key_plan.push_back(k);
	endtask

	task automatic push_digits(string s);
		for (int i = 0; i < s.len(); i++)
			push_key(OP_DIGIT, DIGIT_W'(s[i] - "0"));
	endtask

	// Enter a random decimal operand, mostly short, sometimes long enough to wrap
	task automatic push_number();
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = 0;
		else if (pick <= 6)
			len = $urandom_range(1, 3);
		else if (pick <= 8)
			len = $urandom_range(4, 6);
		else
			len = 10;
		repeat (len)
			push_key(OP_DIGIT, DIGIT_W'($urandom_range(0, 9)));
	endtask

	// Random part: mostly well-formed chains, some noise words
	task automatic build_random_plan();
		int unsigned target;
		int unsigned terms;
		target = key_plan.size() + RANDOM_KEYS;
		while (key_plan.size() < target) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 9) == 0)
					push_key(OP_ALLCLR);
				if ($urandom_range(0, 7) == 0)
					push_key(OP_RECALL);
				else
					push_number();
				terms = $urandom_range(1, 4);
				repeat (terms) begin
					if ($urandom_range(0, 15) == 0)
						push_key(OP_OPER, '0, CODE_W'($urandom_range(OPR_EQ + 1, CODE_TOP)));
					else
						push_key(OP_OPER, '0, CODE_W'($urandom_range(OPR_ADD, OPR_EQ)));
					push_number();
				end
				if ($urandom_range(0, 3) == 0)
					push_key(OP_OPER, '0, OPR_EQ);
				else
					push_key(OP_EQUALS);
				case ($urandom_range(0, 5))
					0: push_key(OP_MEMPLUS);
					1: push_key(OP_MEMCLR);
					2: push_key(OP_RECALL);
					default: ;
				endcase
			end else begin
				repeat ($urandom_range(1, 5))
					push_key(OPER_W'($urandom_range(0, OP_NOP)), DIGIT_W'($urandom),
						CODE_W'($urandom));
			end
		end
	endtask

	// Offer one key word after a random gap and hold it until accepted
	task automatic drive_key(key_word_t k, int unsigned idx);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if ((idx / 64) % 4 == 3)
			gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= k.operation;
		in_ch.digit_value <= k.digit_value;
		in_ch.operator_code <= k.operator_code;
		do @(posedge clk); while (!in_ch.ready);
		shadow.note_key(k);
	endtask

	// Result side: random holds, one long hold-off, no-idle stretches
	initial begin : result_sink
		int unsigned words;
		int unsigned hold;
		words = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, 3);
			if ((words / 64) % 4 == 1)
				hold = 0;
			if (words == HOLDOFF_AT)
				hold = HOLDOFF_CYCLES;
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			shadow.check_readout(out_ch.shown_result, out_ch.shown_display, out_ch.shown_memory,
				out_ch.error_flag);
			words++;
		end
	end

	// Watchdog: end the run when neither channel moves a word for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Reset, directed keys, random keys, drain and report
	initial begin : key_source
		shadow = new();
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_DIGIT;
		in_ch.digit_value <= '0;
		in_ch.operator_code <= OPR_ADD;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Negative entry, digit above nine, memory of -1
		push_key(OP_ALLCLR);
		push_key(OP_OPER, '0, OPR_SUB);
		push_key(OP_DIGIT, 4'd1);
		push_key(OP_EQUALS);
		push_key(OP_MEMPLUS);
		push_key(OP_DIGIT, {DIGIT_W{1'b1}});
		push_key(OP_OPER, '0, OPR_EQ);
		// Build the minimum value, then divide it by -1
		push_digits("65536");
		push_key(OP_OPER, '0, OPR_MUL);
		push_digits("32768");
		push_key(OP_OPER, '0, OPR_DIV);
		push_key(OP_RECALL);
		push_key(OP_EQUALS);
		// Division by zero, equals under the sticky flag, operator keys past it
		push_key(OP_OPER, '0, OPR_DIV);
		push_key(OP_EQUALS);
		push_key(OP_EQUALS);
		push_key(OP_OPER, '0, OPR_ADD);
		push_key(OP_DIGIT, '0);
		push_key(OP_OPER, '0, CODE_TOP);
		push_key(OP_MEMCLR);
		push_key(OP_NOP);
		push_key(OP_ALLCLR);

		build_random_plan();

		foreach (key_plan[i])
			drive_key(key_plan[i], i);
		in_ch.valid <= 1'b0;

		// Drain outstanding readouts, then let stray words show up
		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.outstanding() != 0) begin
			$error("%0d readouts never arrived", shadow.outstanding());
			shadow.failures++;
		end
		$display("Run covered %0d key words and %0d result words, %0d divisions by zero,",
			shadow.keys_seen, shadow.words_checked, shadow.div_zero_events);
		$display("with random gaps on both sides and one long result hold-off.");
		if (shadow.failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== keypad_calculator_core_top.f =====
sv/kcc_pkg.sv
sv/kcc_if.sv
sv/kcc_muldiv.sv
sv/keypad_calculator_core_top.sv
sv/kcc_checker.sv
tb/tb_keypad_calculator_core_top.sv
